// ===== rtl/sla_pkg.sv =====
// shared types and constants of the script line assembler
// result item layout, per-character state, character codes, result kinds and error codes
// no dependencies
package sla_pkg;

  localparam int RES_MAX = 3;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  localparam logic [9:0] DEPTH_MAX = 10'h3FF;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } sla_kind_t;

  typedef enum logic [2:0] {
    ERR_PARENS    = 3'd0,
    ERR_COMMENT   = 3'd1,
    ERR_STRING    = 3'd2,
    ERR_NEG_DEPTH = 3'd3,
    ERR_TOO_LONG  = 3'd4
  } sla_err_t;

  typedef struct packed {
    sla_kind_t  kind;
    logic [7:0] out_byte;
    logic [8:0] position;
    logic [9:0] line_length;
    logic [15:0] line_number;
    logic [8:0] joined_newlines;
    sla_err_t   error_code;
  } sla_result_t;

  // everything but the two line counters, whose width follows the line limit
  typedef struct packed {
    logic [9:0]  paren_depth;
    logic        in_string;
    logic        in_block_comment;
    logic        skip_to_newline;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic        captured_nonspace;
    logic [7:0]  previous_byte;
    logic [15:0] current_line;
    logic [8:0]  paren_newline_count;
    logic [8:0]  pending_line_increment;
    logic        error_latched;
  } sla_state_t;

endpackage

// ===== rtl/sla_char_unit.sv =====
// one plain character applied to the line state: parens, strings, whitespace, line end
// uses sla_pkg; instantiated twice by script_line_assembler
module sla_char_unit #(
  parameter int MAX_LINE = 512
) (
  input  logic                                 en,
  input  logic [7:0]                           ch,
  input  sla_pkg::sla_state_t                  st_i,
  input  logic [$clog2(MAX_LINE+1)-1:0]        tc_i,
  input  logic [$clog2(MAX_LINE+1)-1:0]        trc_i,
  output sla_pkg::sla_state_t                  st_o,
  output logic [$clog2(MAX_LINE+1)-1:0]        tc_o,
  output logic [$clog2(MAX_LINE+1)-1:0]        trc_o,
  output logic                                 res_v,
  output sla_pkg::sla_result_t                 res_o
);
  import sla_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINE);

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  always_comb begin
    logic             cont;
    logic             cap;
    logic [CNT_W+9:0] ext;
    st_o  = st_i;
    tc_o  = tc_i;
    trc_o = trc_i;
    res_v = 1'b0;
    res_o = '0;
    cont  = 1'b0;
    cap   = 1'b0;
    ext   = '0;
    if (en) begin
      if (st_i.in_block_comment) begin
        if (ch == CH_NL) st_o.current_line = st_i.current_line + 16'd1;
      end else begin
        cont = 1'b1;
        case (ch)
          CH_LPAREN: begin
            if (!st_i.in_string && st_i.paren_depth != DEPTH_MAX)
              st_o.paren_depth = st_i.paren_depth + 10'd1;
          end
          CH_RPAREN: begin
            if (!st_i.in_string) begin
              if (st_i.paren_depth == 10'd0) begin
                res_v               = 1'b1;
                res_o.kind          = KIND_ERROR;
                res_o.line_number   = st_i.current_line;
                res_o.error_code    = ERR_NEG_DEPTH;
                st_o.error_latched  = 1'b1;
                cont                = 1'b0;
              end else begin
                st_o.paren_depth = st_i.paren_depth - 10'd1;
              end
            end
          end
          CH_QUOTE: st_o.in_string = !st_i.in_string;
          CH_NL: begin
            if (st_i.paren_depth == 10'd0 && st_i.captured_nonspace) begin
              // line complete
              ext                         = (CNT_W+10)'(trc_i);
              res_v                       = 1'b1;
              res_o.kind                  = KIND_LINE;
              res_o.line_length           = ext[9:0];
              res_o.line_number           = st_i.current_line;
              res_o.joined_newlines       = st_i.paren_newline_count;
              st_o.current_line           = st_i.current_line + 16'd1;
              st_o.pending_line_increment = st_i.paren_newline_count;
              st_o.paren_newline_count    = '0;
              st_o.captured_nonspace      = 1'b0;
              st_o.previous_byte          = '0;
              st_o.in_string              = 1'b0;
              st_o.skip_to_newline        = 1'b0;
              tc_o                        = '0;
              trc_o                       = '0;
              cont                        = 1'b0;
            end else if (st_i.paren_depth != 10'd0) begin
              st_o.paren_newline_count = st_i.paren_newline_count + 9'd1;
            end else begin
              st_o.current_line = st_i.current_line + 16'd1;
            end
          end
          CH_SEMI: begin
            st_o.skip_to_newline = 1'b1;
            cont                 = 1'b0;
          end
          default: begin
            if (is_space(st_i.previous_byte) && is_space(ch) && !st_i.in_string)
              cont = 1'b0;
          end
        endcase
        if (cont) begin
          if (tc_i >= MAX_CNT) begin
            res_v              = 1'b1;
            res_o.kind         = KIND_ERROR;
            res_o.line_number  = st_o.current_line;
            res_o.error_code   = ERR_TOO_LONG;
            st_o.error_latched = 1'b1;
          end else begin
            cap                    = st_i.captured_nonspace || !is_space(ch);
            st_o.captured_nonspace = cap;
            if (cap) begin
              ext            = (CNT_W+10)'(tc_i);
              res_v          = 1'b1;
              res_o.kind     = KIND_CHAR;
              res_o.out_byte = ch;
              res_o.position = ext[8:0];
              tc_o           = tc_i + CNT_W'(1);
              if (!is_space(ch)) trc_o = tc_i + CNT_W'(1);
            end
            st_o.previous_byte = ch;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/script_line_assembler.sv =====
// top level of the script line assembler: input register, line state, result buffer
// uses sla_pkg and sla_char_unit
//
// channel | dir | transaction                    | fields
// --------+-----+--------------------------------+------------------------------------------
// in_     | in  | in_tvalid & in_tready          | tdata: text_byte, tlast: end_of_text
// out_    | out | out_tvalid & out_tready        | tuser: kind, tdata: payload, tlast: last
// cfg_    | in  | cfg_wr_en                      | cfg_wr_data: first_line_number
//
// an accepted byte sits in the input register, then a single pass of
// logic (held byte, then the new byte, then end-of-text checks) updates the line
// state and loads up to three results into the result buffer in the same cycle.
// one transaction per cycle when each gives at most one result and out_tready
// is high; a transaction with more results holds the input side while the buffer drains.
// reset (synchronous, rst_n low) empties both registers, clears the line state
// and sets the first line number back to 1; out_tready low stalls the input side
module script_line_assembler #(
  parameter int MAX_LINE = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] text_byte
  input  logic        in_tlast,     // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte, [16:8] position, [26:17] line_length, [42:27] line_number,
  // [51:43] joined_newlines, [54:52] error_code, [55] zero
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser,    // [1:0] kind
  output logic        out_tlast,    // last
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data   // first_line_number
);
  import sla_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE + 1);

  // line state out of reset: everything clear, first line number 1
  localparam sla_state_t ST_RESET = '{current_line: 16'd1, default: '0};

  // input register
  logic             in_v_r;
  logic [7:0]       in_byte_r;
  logic             in_eot_r;

  // line state
  sla_state_t       st_r;
  logic [CNT_W-1:0] tc_r;
  logic [CNT_W-1:0] trc_r;
  logic [15:0]      first_line_r;

  // result buffer
  sla_result_t      obuf_r [RES_MAX];
  logic [1:0]       ocnt_r;
  logic [1:0]       oidx_r;

  logic             obuf_free;
  logic             commit;

  // single pass signals
  sla_state_t       st_pre;
  logic             a_en;
  logic             pair_hit;
  sla_state_t       st_a;
  logic [CNT_W-1:0] tc_a;
  logic [CNT_W-1:0] trc_a;
  logic             a_rv;
  sla_result_t      a_res;
  sla_state_t       st_b_in;
  logic             b_en;
  sla_state_t       st_b;
  logic [CNT_W-1:0] tc_b;
  logic [CNT_W-1:0] trc_b;
  logic             b_rv;
  sla_result_t      b_res;

  sla_state_t       st_nxt;
  logic [CNT_W-1:0] tc_nxt;
  logic [CNT_W-1:0] trc_nxt;
  sla_result_t      slot_nxt [RES_MAX];
  logic [1:0]       ocnt_nxt;

  sla_state_t       st_cfg;

  sla_result_t      cur;

  // handshake: the buffer is free when empty or its last result leaves now
  assign obuf_free = (oidx_r == ocnt_r) || (out_tready && (oidx_r + 2'd1 == ocnt_r));
  assign commit    = in_v_r && obuf_free;
  assign in_tready = !in_v_r || commit;

  // pending line increment folds in first; a held byte pairs with the new byte
  always_comb begin
    st_pre                        = st_r;
    st_pre.current_line           = st_r.current_line + 16'(st_r.pending_line_increment);
    st_pre.pending_line_increment = '0;
    st_pre.held_valid             = 1'b0;
    a_en                          = 1'b0;
    pair_hit                      = 1'b0;
    if (st_r.held_valid) begin
      if (!in_eot_r && st_r.held_byte == CH_SLASH && in_byte_r == CH_STAR) begin
        st_pre.in_block_comment = 1'b1;
        pair_hit                = 1'b1;
      end else if (!in_eot_r && st_r.held_byte == CH_STAR && in_byte_r == CH_SLASH) begin
        st_pre.in_block_comment = 1'b0;
        pair_hit                = 1'b1;
      end else begin
        a_en = 1'b1;
      end
    end
  end

  // held byte that found no partner is a plain character
  sla_char_unit #(.MAX_LINE(MAX_LINE)) u_held (
    .en    (a_en),
    .ch    (st_r.held_byte),
    .st_i  (st_pre),
    .tc_i  (tc_r),
    .trc_i (trc_r),
    .st_o  (st_a),
    .tc_o  (tc_a),
    .trc_o (trc_a),
    .res_v (a_rv),
    .res_o (a_res)
  );

  // new byte: comment skipping, then hold a possible comment opener or closer
  always_comb begin
    st_b_in = st_a;
    b_en    = 1'b0;
    if (!in_eot_r && !pair_hit && !st_a.error_latched) begin
      if (st_a.skip_to_newline && in_byte_r != CH_NL) begin
        b_en = 1'b0;
      end else begin
        st_b_in.skip_to_newline = 1'b0;
        if ((!st_a.in_block_comment && !st_a.in_string && in_byte_r == CH_SLASH) ||
            (st_a.in_block_comment && in_byte_r == CH_STAR)) begin
          st_b_in.held_byte  = in_byte_r;
          st_b_in.held_valid = 1'b1;
        end else begin
          b_en = 1'b1;
        end
      end
    end
  end

  sla_char_unit #(.MAX_LINE(MAX_LINE)) u_new (
    .en    (b_en),
    .ch    (in_byte_r),
    .st_i  (st_b_in),
    .tc_i  (tc_a),
    .trc_i (trc_a),
    .st_o  (st_b),
    .tc_o  (tc_b),
    .trc_o (trc_b),
    .res_v (b_rv),
    .res_o (b_res)
  );

  // end-of-text checks, next state and result collection
  always_comb begin
    logic [CNT_W+9:0] trc_ext;
    sla_result_t      r;
    trc_ext  = (CNT_W+10)'(trc_a);
    r        = '0;
    st_nxt   = st_r;
    tc_nxt   = tc_r;
    trc_nxt  = trc_r;
    ocnt_nxt = 2'd0;
    for (int i = 0; i < RES_MAX; i++) slot_nxt[i] = '0;
    if (in_eot_r) begin
      if (!st_r.error_latched) begin
        if (a_rv) begin
          slot_nxt[ocnt_nxt] = a_res;
          ocnt_nxt           = ocnt_nxt + 2'd1;
        end
        if (!st_a.error_latched) begin
          r             = '0;
          r.line_number = st_a.current_line;
          r.kind        = KIND_ERROR;
          if (st_a.in_block_comment) begin
            r.error_code       = ERR_COMMENT;
            slot_nxt[ocnt_nxt] = r;
            ocnt_nxt           = ocnt_nxt + 2'd1;
          end else if (st_a.in_string) begin
            r.error_code       = ERR_STRING;
            slot_nxt[ocnt_nxt] = r;
            ocnt_nxt           = ocnt_nxt + 2'd1;
          end else if (st_a.paren_depth != 10'd0) begin
            r.error_code       = ERR_PARENS;
            slot_nxt[ocnt_nxt] = r;
            ocnt_nxt           = ocnt_nxt + 2'd1;
          end else begin
            if (st_a.captured_nonspace) begin
              // pending line closes at end of text
              r                  = '0;
              r.kind             = KIND_LINE;
              r.line_length      = trc_ext[9:0];
              r.line_number      = st_a.current_line;
              r.joined_newlines  = st_a.paren_newline_count;
              slot_nxt[ocnt_nxt] = r;
              ocnt_nxt           = ocnt_nxt + 2'd1;
            end
            r                  = '0;
            r.kind             = KIND_END;
            slot_nxt[ocnt_nxt] = r;
            ocnt_nxt           = ocnt_nxt + 2'd1;
          end
        end
      end
      // every end of text restarts for a new text
      st_nxt              = '0;
      st_nxt.current_line = first_line_r;
      tc_nxt              = '0;
      trc_nxt             = '0;
    end else if (!st_r.error_latched) begin
      if (a_rv) begin
        slot_nxt[ocnt_nxt] = a_res;
        ocnt_nxt           = ocnt_nxt + 2'd1;
      end
      if (b_rv) begin
        slot_nxt[ocnt_nxt] = b_res;
        ocnt_nxt           = ocnt_nxt + 2'd1;
      end
      st_nxt  = st_b;
      tc_nxt  = tc_b;
      trc_nxt = trc_b;
    end
  end

  // a new first line number also restarts the line count at once
  always_comb begin
    st_cfg                        = st_r;
    st_cfg.current_line           = cfg_wr_data;
    st_cfg.pending_line_increment = '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      st_r         <= ST_RESET;
      tc_r         <= '0;
      trc_r        <= '0;
      first_line_r <= 16'd1;
      ocnt_r       <= 2'd0;
      oidx_r       <= 2'd0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (commit) begin
        tc_r   <= tc_nxt;
        trc_r  <= trc_nxt;
        ocnt_r <= ocnt_nxt;
        oidx_r <= 2'd0;
      end else if (out_tvalid && out_tready) begin
        oidx_r <= oidx_r + 2'd1;
      end
      // configuration must arrive only while idle; the block does not enforce this
      if (cfg_wr_en) begin
        first_line_r <= cfg_wr_data;
        st_r         <= st_cfg;
      end else if (commit) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
    if (commit) begin
      for (int i = 0; i < RES_MAX; i++) obuf_r[i] <= slot_nxt[i];
    end
  end

  // result channel
  assign cur        = obuf_r[oidx_r];
  assign out_tvalid = (oidx_r != ocnt_r);
  assign out_tlast  = (oidx_r + 2'd1 == ocnt_r);
  assign out_tuser  = cur.kind;
  assign out_tdata  = {1'b0, cur.error_code, cur.joined_newlines, cur.line_number,
                       cur.line_length, cur.position, cur.out_byte};

endmodule
